[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an asynchronous active-low reset that disables it.
`define SME_ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset names.
`define SME_ASSERT(lbl, prop, msg) `SME_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

[rtl/sme_pkg.sv]
// Package of the stack machine executor: sizes, codes and shared types.
package sme_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int WORD_W      = 32;

	typedef enum logic [3:0] {
		OP_END   = 4'd0,
		OP_PUSH  = 4'd1,
		OP_POP   = 4'd2,
		OP_ADD   = 4'd3,
		OP_SUB   = 4'd4,
		OP_MUL   = 4'd5,
		OP_DIV   = 4'd6,
		OP_MOD   = 4'd7,
		OP_LT    = 4'd8,
		OP_LE    = 4'd9,
		OP_GT    = 4'd10,
		OP_GE    = 4'd11,
		OP_PRINT = 4'd12,
		OP_EQ    = 4'd13,
		OP_NEQ   = 4'd14
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_PRINTED   = 3'd1,
		ST_HALTED    = 3'd2,
		ST_IGNORED   = 3'd3,
		ST_UNDERFLOW = 3'd4,
		ST_OVERFLOW  = 3'd5,
		ST_DIVZERO   = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		CLS_END,
		CLS_PUSH,
		CLS_POP,
		CLS_PRINT,
		CLS_BIN,
		CLS_NOP
	} cls_t;

	// Classified instruction as it travels from the front to the back.
	typedef struct packed {
		cls_t              cls;
		logic [3:0]        op;
		logic [WORD_W-1:0] imm;
	} cmd_t;

	// One result beat.
	typedef struct packed {
		status_t            status;
		logic [WORD_W-1:0]  pval;
		logic [DEPTH_W-1:0] depth;
	} res_t;

endpackage

[rtl/sme_if.sv]
// Channel interfaces of the stack machine executor: instruction and result.
interface sme_in_if;
	logic                               valid;
	logic                               ready;
	logic [3:0]                         op;
	logic signed [sme_pkg::WORD_W-1:0]  immediate;

	modport source (output valid, output op, output immediate, input ready);
	modport sink   (input valid, input op, input immediate, output ready);
endinterface

interface sme_out_if;
	logic                                valid;
	logic                                ready;
	logic [2:0]                          status;
	logic signed [sme_pkg::WORD_W-1:0]   print_value;
	logic [sme_pkg::DEPTH_W-1:0]         stack_depth;

	modport source (output valid, output status, output print_value, output stack_depth,
		input ready);
	modport sink   (input valid, input status, input print_value, input stack_depth,
		output ready);
endinterface

[rtl/sme_front.sv]
// Front end: accepts instruction beats, classifies them and queues them for the back end.
module sme_front (
	input  logic           clk,
	input  logic           arst_n,
	sme_in_if.sink         cmd,
	output logic           q_valid,
	input  logic           q_ready,
	output sme_pkg::cmd_t  q_item
);

	sme_pkg::cmd_t fifo_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	sme_pkg::cmd_t cls_item;
	logic          push;
	logic          pop;

	always_comb begin
		cls_item.op  = cmd.op;
		cls_item.imm = cmd.immediate;
		case (cmd.op) inside
			sme_pkg::OP_END:                 cls_item.cls = sme_pkg::CLS_END;
			sme_pkg::OP_PUSH:                cls_item.cls = sme_pkg::CLS_PUSH;
			sme_pkg::OP_POP:                 cls_item.cls = sme_pkg::CLS_POP;
			sme_pkg::OP_PRINT:               cls_item.cls = sme_pkg::CLS_PRINT;
			[sme_pkg::OP_ADD:sme_pkg::OP_GE],
			sme_pkg::OP_EQ, sme_pkg::OP_NEQ: cls_item.cls = sme_pkg::CLS_BIN;
			default:                         cls_item.cls = sme_pkg::CLS_NOP;
		endcase
	end

	assign cmd.ready = (count_q != 2'd2);
	assign push      = cmd.valid && cmd.ready;
	assign q_valid   = (count_q != 2'd0);
	assign pop       = q_valid && q_ready;
	assign q_item    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[rtl/sme_back.sv]
// Back end: stack storage, arithmetic, the iterative divider and the result register.
module sme_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  sme_pkg::cmd_t  q_item,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output sme_pkg::res_t  rsp_data
);

	localparam int W  = sme_pkg::WORD_W;
	localparam int DW = sme_pkg::DEPTH_W;
	localparam int AW = sme_pkg::ADDR_W;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_DWB} state_t;

	state_t           state_q, state_d;
	logic [DW-1:0]    depth_q, depth_d;
	logic             running_q, running_d;
	logic [W-1:0]     tos_q, tos_d;
	sme_pkg::cmd_t    cur_q, cur_d;
	logic [W-1:0]     rd_q;
	logic [W-1:0]     mem [sme_pkg::STACK_DEPTH];
	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_wa, mem_ra;
	logic [DW-1:0]    depth_m1, depth_m2;

	logic [2*W-1:0]   div_rem_q, div_rem_d;
	logic [2*W-1:0]   div_quo_q, div_quo_d;
	logic [2*W-1:0]   div_b_q, div_b_d;
	logic [5:0]       div_cnt_q, div_cnt_d;
	logic [2*W:0]     div_shift;
	logic [2*W:0]     div_diff;

	logic             out_valid_q;
	sme_pkg::res_t    out_q;
	logic             out_free;
	logic             emit;
	sme_pkg::res_t    emit_res;
	logic [W-1:0]     a_w, b_w, bin_r;
	logic             is_div;

	assign out_free  = !out_valid_q || rsp_ready;
	assign q_ready   = (state_q == S_IDLE) && out_free;
	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;
	assign depth_m1  = depth_q - DW'(1);
	assign depth_m2  = depth_q - DW'(2);

	assign a_w    = rd_q;
	assign b_w    = tos_q;
	assign is_div = (cur_q.op == sme_pkg::OP_DIV) || (cur_q.op == sme_pkg::OP_MOD);

	always_comb begin
		case (cur_q.op)
			sme_pkg::OP_ADD: bin_r = a_w + b_w;
			sme_pkg::OP_SUB: bin_r = a_w - b_w;
			sme_pkg::OP_MUL: bin_r = a_w * b_w;
			sme_pkg::OP_LT:  bin_r = W'(a_w < b_w);
			sme_pkg::OP_LE:  bin_r = W'(a_w <= b_w);
			sme_pkg::OP_GT:  bin_r = W'(a_w > b_w);
			sme_pkg::OP_GE:  bin_r = W'(a_w >= b_w);
			sme_pkg::OP_EQ:  bin_r = W'(a_w == b_w);
			default:         bin_r = W'(a_w != b_w);
		endcase
	end

	// One restoring step of the 64-bit unsigned divider.
	assign div_shift = {div_rem_q, div_quo_q[2*W-1]};
	assign div_diff  = div_shift - {1'b0, div_b_q};

	always_comb begin
		state_d   = state_q;
		depth_d   = depth_q;
		running_d = running_q;
		tos_d     = tos_q;
		cur_d     = cur_q;
		div_rem_d = div_rem_q;
		div_quo_d = div_quo_q;
		div_b_d   = div_b_q;
		div_cnt_d = div_cnt_q;
		mem_we    = 1'b0;
		mem_wa    = depth_m1[AW-1:0];
		mem_re    = 1'b0;
		mem_ra    = depth_m2[AW-1:0];
		emit      = 1'b0;
		emit_res  = '{status: sme_pkg::ST_OK, pval: '0, depth: depth_q};

		unique case (state_q)
			S_IDLE: begin
				if (q_valid && q_ready) begin
					cur_d = q_item;
					if (!running_q) begin
						emit            = 1'b1;
						emit_res.status = sme_pkg::ST_IGNORED;
					end else begin
						unique case (q_item.cls)
							sme_pkg::CLS_END: begin
								running_d       = 1'b0;
								emit            = 1'b1;
								emit_res.status = sme_pkg::ST_HALTED;
							end
							sme_pkg::CLS_PUSH: begin
								emit = 1'b1;
								if (depth_q == DW'(sme_pkg::STACK_DEPTH)) begin
									emit_res.status = sme_pkg::ST_OVERFLOW;
								end else begin
									mem_we         = (depth_q != '0);
									tos_d          = q_item.imm;
									depth_d        = depth_q + DW'(1);
									emit_res.depth = depth_q + DW'(1);
								end
							end
							sme_pkg::CLS_POP, sme_pkg::CLS_PRINT: begin
								if (depth_q == '0) begin
									emit            = 1'b1;
									emit_res.status = sme_pkg::ST_UNDERFLOW;
								end else if (depth_q == DW'(1)) begin
									emit           = 1'b1;
									depth_d        = '0;
									emit_res.depth = '0;
									if (q_item.cls == sme_pkg::CLS_PRINT) begin
										emit_res.status = sme_pkg::ST_PRINTED;
										emit_res.pval   = tos_q;
									end
								end else begin
									mem_re  = 1'b1;
									state_d = S_EXEC;
								end
							end
							sme_pkg::CLS_BIN: begin
								if (depth_q < DW'(2)) begin
									emit            = 1'b1;
									emit_res.status = sme_pkg::ST_UNDERFLOW;
								end else begin
									mem_re  = 1'b1;
									state_d = S_EXEC;
								end
							end
							default: begin
								emit = 1'b1;
							end
						endcase
					end
				end
			end
			S_EXEC: begin
				if (cur_q.cls == sme_pkg::CLS_BIN && is_div && b_w != '0) begin
					div_rem_d = '0;
					div_quo_d = {{W{a_w[W-1]}}, a_w};
					div_b_d   = {{W{b_w[W-1]}}, b_w};
					div_cnt_d = '0;
					state_d   = S_DIV;
				end else if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					if (cur_q.cls == sme_pkg::CLS_BIN && is_div) begin
						emit_res.status = sme_pkg::ST_DIVZERO;
					end else begin
						depth_d        = depth_m1;
						emit_res.depth = depth_m1;
						if (cur_q.cls == sme_pkg::CLS_BIN) begin
							tos_d = bin_r;
						end else begin
							tos_d = rd_q;
							if (cur_q.cls == sme_pkg::CLS_PRINT) begin
								emit_res.status = sme_pkg::ST_PRINTED;
								emit_res.pval   = tos_q;
							end
						end
					end
				end
			end
			S_DIV: begin
				if (!div_diff[2*W]) begin
					div_rem_d = div_diff[2*W-1:0];
					div_quo_d = {div_quo_q[2*W-2:0], 1'b1};
				end else begin
					div_rem_d = div_shift[2*W-1:0];
					div_quo_d = {div_quo_q[2*W-2:0], 1'b0};
				end
				div_cnt_d = div_cnt_q + 6'd1;
				if (div_cnt_q == '1) begin
					state_d = S_DWB;
				end
			end
			S_DWB: begin
				if (out_free) begin
					emit           = 1'b1;
					state_d        = S_IDLE;
					depth_d        = depth_m1;
					emit_res.depth = depth_m1;
					tos_d          = (cur_q.op == sme_pkg::OP_DIV) ? div_quo_q[W-1:0]
						: div_rem_q[W-1:0];
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= tos_q;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		tos_q     <= tos_d;
		cur_q     <= cur_d;
		div_rem_q <= div_rem_d;
		div_quo_q <= div_quo_d;
		div_b_q   <= div_b_d;
		div_cnt_q <= div_cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			running_q   <= 1'b1;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			state_q   <= state_d;
			depth_q   <= depth_d;
			running_q <= running_d;
			if (emit) begin
				out_q <= emit_res;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/stack_machine_executor.sv]
// Top level of the stack machine executor: front end, queue and back end.
//
// The block runs one stack-machine instruction per beat on the cmd channel
// (op and immediate) and returns exactly one beat per instruction on the rsp
// channel (status, print_value, stack_depth), in order.
// A two-entry queue in the front end decouples instruction intake from
// execution, so cmd keeps being taken while the back end is busy.
// The top of stack lives in a register; the words below it sit in a
// single-port memory with a registered read.
// Push, end, no-op, a pop or print of the last word and any instruction that
// fails its depth check finish in S_IDLE; other pops and prints and the
// binary operations go on to S_EXEC, which uses the registered memory
// read of the word below the top. Div and mod then run in S_DIV on a 64-bit
// divider that yields one bit per cycle, and write back in S_DWB.
// At the earliest a result passes a queue entry, then the result register.
// Reset empties the stack and sets the machine running; the stack memory is
// not cleared, as only words written by a push are ever read.
// If rsp is stalled the result register holds its beat and the back end
// waits; the queue then fills and cmd.ready drops.
module stack_machine_executor (
	input  logic       clk,
	input  logic       arst_n,
	sme_in_if.sink     cmd,
	sme_out_if.source  rsp
);

	logic          q_valid;
	logic          q_ready;
	sme_pkg::cmd_t q_item;
	sme_pkg::res_t res;

	// Intake and classification.
	sme_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item)
	);

	// Execution and the result register.
	sme_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (res)
	);

	assign rsp.status      = res.status;
	assign rsp.print_value = res.pval;
	assign rsp.stack_depth = res.depth;

endmodule

[rtl/sme_checker.sv]
// Port-level checker of the stack machine executor and its bind.
`include "assert_macros.svh"

module sme_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [2:0]                  rsp_status,
	input logic [sme_pkg::WORD_W-1:0]  rsp_pval,
	input logic [sme_pkg::DEPTH_W-1:0] rsp_depth
);

	logic halted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
		end else if (rsp_valid && rsp_ready && rsp_status == sme_pkg::ST_HALTED) begin
			halted_q <= 1'b1;
		end
	end

	`SME_ASSERT(a_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_pval) && $stable(rsp_depth), "result beat changed while stalled")
	`SME_ASSERT(a_after_halt, rsp_valid && halted_q |-> rsp_status == sme_pkg::ST_IGNORED, "beat after halt not ignored")
	`SME_ASSERT(a_pval_zero, rsp_valid && rsp_status != sme_pkg::ST_PRINTED |-> rsp_pval == '0, "print value set without print")
	`SME_ASSERT(a_depth_max, rsp_valid |-> rsp_depth <= sme_pkg::DEPTH_W'(sme_pkg::STACK_DEPTH), "stack depth beyond capacity")

endmodule

bind stack_machine_executor sme_checker u_sme_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_pval   (rsp.print_value),
	.rsp_depth  (rsp.stack_depth)
);
